// ===== hdl/rgb_led_pattern_generator_macros.svh =====
// Assertion macros for the RGB LED pattern generator.
// No dependencies; included by the modules that carry assertions.
`ifndef RGB_LED_PATTERN_GENERATOR_MACROS_SVH
`define RGB_LED_PATTERN_GENERATOR_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define RGBPG_ASSERT_IMP(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error("rgbpg assertion failed");
// next-cycle implication
`define RGBPG_ASSERT_NXT(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error("rgbpg assertion failed");
`else
`define RGBPG_ASSERT_IMP(label, clk, rstn, pre, post)
`define RGBPG_ASSERT_NXT(label, clk, rstn, pre, post)
`endif
`endif

// ===== hdl/rgbpg_pkg.sv =====
// Shared types, constants and microcode table of the RGB LED pattern generator.
// No dependencies.
`default_nettype none

package rgbpg_pkg;

    localparam int PC_W = 4;
    typedef logic [PC_W-1:0] pc_t;

    localparam pc_t PC_IDLE   = 4'd0;
    localparam pc_t PC_DECODE = 4'd1;
    localparam pc_t PC_LEVEL  = 4'd2;
    localparam pc_t PC_LVDIV  = 4'd3;
    localparam pc_t PC_SCALE  = 4'd4;
    localparam pc_t PC_RDIV   = 4'd5;
    localparam pc_t PC_GDIV   = 4'd6;
    localparam pc_t PC_BDIV   = 4'd7;
    localparam pc_t PC_EMIT   = 4'd8;

    typedef enum logic [1:0] {A_LEVEL, A_RED, A_GREEN, A_BLUE} asel_t;
    typedef enum logic [2:0] {D_NONE, D_SCALE, D_RED, D_GREEN, D_BLUE} dst_t;
    typedef enum logic [2:0] {J_NEXT, J_WAIT_IN, J_DISPATCH, J_GOTO, J_WAIT_OUT} jmp_t;

    typedef struct packed {
        asel_t a_sel;
        dst_t  dst;
        jmp_t  jmp;
        pc_t   target;
    } uword_t;

    typedef struct packed {
        logic in_xfer;
        logic out_free;
        pc_t  dispatch;
    } seq_cond_t;

    localparam logic [2:0] MODE_OFF     = 3'd0;
    localparam logic [2:0] MODE_SOLID   = 3'd1;
    localparam logic [2:0] MODE_SLOW    = 3'd2;
    localparam logic [2:0] MODE_FAST    = 3'd3;
    localparam logic [2:0] MODE_PULSE   = 3'd4;
    localparam logic [2:0] MODE_RAINBOW = 3'd5;

    localparam logic [2:0] REG_MODE   = 3'd0;
    localparam logic [2:0] REG_RED    = 3'd1;
    localparam logic [2:0] REG_GREEN  = 3'd2;
    localparam logic [2:0] REG_BLUE   = 3'd3;
    localparam logic [2:0] REG_BRIGHT = 3'd4;
    localparam logic [2:0] REG_ENABLE = 3'd5;

    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_START = 1'b1;

    localparam int SLOW_MS    = 500;
    localparam int FAST_MS    = 100;
    localparam int PULSE_MS   = 20;
    localparam int RAINBOW_MS = 50;

    localparam logic [7:0] PULSE_STEP   = 8'd5;
    localparam logic [7:0] PULSE_MIN    = 8'd10;
    localparam logic [7:0] PULSE_MAX    = 8'd255;
    localparam logic [7:0] PULSE_TURN   = 8'd15;
    localparam logic [7:0] WHEEL_SEG1   = 8'd85;
    localparam logic [7:0] WHEEL_SEG2   = 8'd170;
    localparam logic [7:0] BRIGHT_RESET = 8'd50;

    function automatic uword_t ucode(pc_t pc);
        uword_t w;
        w = '{a_sel: A_LEVEL, dst: D_NONE, jmp: J_GOTO, target: PC_IDLE};
        case (pc)
            PC_IDLE:   w = '{a_sel: A_LEVEL, dst: D_NONE,  jmp: J_WAIT_IN,  target: PC_IDLE};
            PC_DECODE: w = '{a_sel: A_LEVEL, dst: D_NONE,  jmp: J_DISPATCH, target: PC_IDLE};
            PC_LEVEL:  w = '{a_sel: A_LEVEL, dst: D_NONE,  jmp: J_NEXT,     target: PC_IDLE};
            PC_LVDIV:  w = '{a_sel: A_RED,   dst: D_SCALE, jmp: J_NEXT,     target: PC_IDLE};
            PC_SCALE:  w = '{a_sel: A_RED,   dst: D_NONE,  jmp: J_NEXT,     target: PC_IDLE};
            PC_RDIV:   w = '{a_sel: A_GREEN, dst: D_RED,   jmp: J_NEXT,     target: PC_IDLE};
            PC_GDIV:   w = '{a_sel: A_BLUE,  dst: D_GREEN, jmp: J_NEXT,     target: PC_IDLE};
            PC_BDIV:   w = '{a_sel: A_BLUE,  dst: D_BLUE,  jmp: J_GOTO,     target: PC_EMIT};
            PC_EMIT:   w = '{a_sel: A_LEVEL, dst: D_NONE,  jmp: J_WAIT_OUT, target: PC_IDLE};
            default:   w = '{a_sel: A_LEVEL, dst: D_NONE,  jmp: J_GOTO,     target: PC_IDLE};
        endcase
        return w;
    endfunction

    // three-segment color wheel, returns {red, green, blue}
    function automatic logic [23:0] wheel(logic [7:0] pos);
        logic [7:0] p;
        logic [7:0] t;
        logic [23:0] c;
        if (pos < WHEEL_SEG1) begin
            p = pos;
        end else if (pos < WHEEL_SEG2) begin
            p = pos - WHEEL_SEG1;
        end else begin
            p = pos - WHEEL_SEG2;
        end
        t = p + {p[6:0], 1'b0};
        if (pos < WHEEL_SEG1) begin
            c = {t, 8'd255 - t, 8'd0};
        end else if (pos < WHEEL_SEG2) begin
            c = {8'd255 - t, 8'd0, t};
        end else begin
            c = {8'd0, t, 8'd255 - t};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/rgb_led_pattern_generator.sv =====
// RGB LED pattern generator for one LED: APB register file, decode and state update,
// microcoded scaling datapath. Depends on rgbpg_pkg, rgbpg_seq, rgbpg_scaler and the macro header.
//
// Usage:
//   Input channel (s_valid/s_ready): s_op = 1 starts a pattern at s_now_ms, s_op = 0 is a
//   time tick. Each transfer gives zero or one color on the output channel (m_valid/m_ready).
//   APB registers at byte address 4*i: mode, base red/green/blue, brightness, enable.
//   Path from input transfer to m_valid: DECODE goes straight to EMIT for black, through
//   SCALE, RDIV, GDIV and BDIV to EMIT for a brightness-scaled color, and through LEVEL and
//   LVDIV before those for pulse (an extra multiply for the pulse level). An item that gives
//   no result frees the input as DECODE returns to IDLE. The item rate is set by the single
//   shared 8x8 multiplier and divide-by-255 unit, used once per scale factor and per channel.
//   One item is in flight at a time; the next is taken while a result waits in the output
//   register. If the receiver stalls and a second result is ready, the sequencer holds in
//   its emit step until the output register is free.
//   Reset (aresetn low, synchronous) loads the register defaults (brightness 50, enabled),
//   clears the pattern state and empties the output register.
`default_nettype none
`include "rgb_led_pattern_generator_macros.svh"

module rgb_led_pattern_generator #(
    parameter int TIME_BITS = 32
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // APB configuration port
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [4:0]           paddr,
    input  wire logic [31:0]          pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    // input channel
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic                 s_op,
    input  wire logic [TIME_BITS-1:0] s_now_ms,
    // result channel
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [7:0]                m_red,
    output logic [7:0]                m_green,
    output logic [7:0]                m_blue
);

    // configuration
    logic [2:0] mode_reg;
    logic [7:0] base_red_reg;
    logic [7:0] base_green_reg;
    logic [7:0] base_blue_reg;
    logic [7:0] brightness_reg;
    logic       enabled_reg;

    // pattern state
    logic [TIME_BITS-1:0] last_reg;
    logic [TIME_BITS-1:0] last_next;
    logic [7:0]           phase_reg;
    logic [7:0]           phase_next;
    logic [7:0]           pulse_level_reg;
    logic [7:0]           pulse_level_next;
    logic                 pulse_rising_reg;
    logic                 pulse_rising_next;

    // datapath
    logic                 op_reg;
    logic [TIME_BITS-1:0] now_reg;
    logic [2:0][7:0]      col_reg;
    logic [7:0]           scale_reg;
    logic [2:0][7:0]      dec_col;
    logic                 dec_load;
    rgbpg_pkg::pc_t       dispatch;
    logic [TIME_BITS-1:0] diff;
    logic [TIME_BITS-1:0] interval;
    logic [8:0]           level_sum;
    logic [7:0]           mul_a;
    logic [7:0]           quot;

    // output register
    logic       m_valid_reg;
    logic       m_valid_next;
    logic [7:0] m_red_reg;
    logic [7:0] m_green_reg;
    logic [7:0] m_blue_reg;

    rgbpg_pkg::uword_t    uw;
    rgbpg_pkg::seq_cond_t cond;
    logic                 s_xfer;
    logic                 cfg_wr;
    logic                 decode;
    logic                 emit;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign s_ready = (uw.jmp == rgbpg_pkg::J_WAIT_IN);
    assign s_xfer  = s_valid & s_ready;
    assign decode  = (uw.jmp == rgbpg_pkg::J_DISPATCH);
    assign emit    = (uw.jmp == rgbpg_pkg::J_WAIT_OUT) & cond.out_free;

    assign cond.in_xfer  = s_xfer;
    assign cond.out_free = !m_valid_reg || m_ready;
    assign cond.dispatch = dispatch;

    rgbpg_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cond    (cond),
        .uw      (uw)
    );

    always_comb begin
        case (uw.a_sel)
            rgbpg_pkg::A_LEVEL: mul_a = pulse_level_reg;
            rgbpg_pkg::A_RED:   mul_a = col_reg[2];
            rgbpg_pkg::A_GREEN: mul_a = col_reg[1];
            rgbpg_pkg::A_BLUE:  mul_a = col_reg[0];
            default:            mul_a = pulse_level_reg;
        endcase
    end

    rgbpg_scaler u_scaler (
        .aclk (aclk),
        .a    (mul_a),
        .b    (scale_reg),
        .quot (quot)
    );

    // APB
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= rgbpg_pkg::MODE_OFF;
            base_red_reg   <= 8'd0;
            base_green_reg <= 8'd0;
            base_blue_reg  <= 8'd0;
            brightness_reg <= rgbpg_pkg::BRIGHT_RESET;
            enabled_reg    <= 1'b1;
        end else if (cfg_wr) begin
            case (paddr[4:2])
                rgbpg_pkg::REG_MODE:   mode_reg       <= pwdata[2:0];
                rgbpg_pkg::REG_RED:    base_red_reg   <= pwdata[7:0];
                rgbpg_pkg::REG_GREEN:  base_green_reg <= pwdata[7:0];
                rgbpg_pkg::REG_BLUE:   base_blue_reg  <= pwdata[7:0];
                rgbpg_pkg::REG_BRIGHT: brightness_reg <= pwdata[7:0];
                rgbpg_pkg::REG_ENABLE: enabled_reg    <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            rgbpg_pkg::REG_MODE:   prdata = {29'd0, mode_reg};
            rgbpg_pkg::REG_RED:    prdata = {24'd0, base_red_reg};
            rgbpg_pkg::REG_GREEN:  prdata = {24'd0, base_green_reg};
            rgbpg_pkg::REG_BLUE:   prdata = {24'd0, base_blue_reg};
            rgbpg_pkg::REG_BRIGHT: prdata = {24'd0, brightness_reg};
            rgbpg_pkg::REG_ENABLE: prdata = {31'd0, enabled_reg};
            default:               prdata = 32'd0;
        endcase
    end

    // decode step
    assign diff      = now_reg - last_reg;
    assign level_sum = {1'b0, pulse_level_reg} + {1'b0, rgbpg_pkg::PULSE_STEP};

    always_comb begin
        case (mode_reg)
            rgbpg_pkg::MODE_SLOW:    interval = TIME_BITS'(rgbpg_pkg::SLOW_MS);
            rgbpg_pkg::MODE_FAST:    interval = TIME_BITS'(rgbpg_pkg::FAST_MS);
            rgbpg_pkg::MODE_PULSE:   interval = TIME_BITS'(rgbpg_pkg::PULSE_MS);
            rgbpg_pkg::MODE_RAINBOW: interval = TIME_BITS'(rgbpg_pkg::RAINBOW_MS);
            default:                 interval = '0;
        endcase
    end

    always_comb begin
        last_next         = last_reg;
        phase_next        = phase_reg;
        pulse_level_next  = pulse_level_reg;
        pulse_rising_next = pulse_rising_reg;
        dec_col           = {base_red_reg, base_green_reg, base_blue_reg};
        dec_load          = 1'b0;
        dispatch          = rgbpg_pkg::PC_IDLE;
        if (op_reg == rgbpg_pkg::OP_START) begin
            last_next         = now_reg;
            phase_next        = 8'd0;
            pulse_level_next  = 8'd0;
            pulse_rising_next = 1'b1;
            if (!enabled_reg || mode_reg == rgbpg_pkg::MODE_OFF) begin
                dec_col  = '0;
                dec_load = 1'b1;
                dispatch = rgbpg_pkg::PC_EMIT;
            end else if (mode_reg == rgbpg_pkg::MODE_SOLID) begin
                dec_load = 1'b1;
                dispatch = rgbpg_pkg::PC_SCALE;
            end
        end else if (enabled_reg && diff >= interval) begin
            case (mode_reg)
                rgbpg_pkg::MODE_SLOW, rgbpg_pkg::MODE_FAST: begin
                    last_next  = now_reg;
                    phase_next = (phase_reg == 8'd0) ? 8'd1 : 8'd0;
                    dec_load   = 1'b1;
                    if (phase_reg == 8'd0) begin
                        dispatch = rgbpg_pkg::PC_SCALE;
                    end else begin
                        dec_col  = '0;
                        dispatch = rgbpg_pkg::PC_EMIT;
                    end
                end
                rgbpg_pkg::MODE_PULSE: begin
                    last_next = now_reg;
                    if (pulse_rising_reg) begin
                        if (level_sum >= {1'b0, rgbpg_pkg::PULSE_MAX}) begin
                            pulse_level_next  = rgbpg_pkg::PULSE_MAX;
                            pulse_rising_next = 1'b0;
                        end else begin
                            pulse_level_next = level_sum[7:0];
                        end
                    end else if (pulse_level_reg <= rgbpg_pkg::PULSE_TURN) begin
                        pulse_level_next  = rgbpg_pkg::PULSE_MIN;
                        pulse_rising_next = 1'b1;
                    end else begin
                        pulse_level_next = pulse_level_reg - rgbpg_pkg::PULSE_STEP;
                    end
                    dec_load = 1'b1;
                    dispatch = rgbpg_pkg::PC_LEVEL;
                end
                rgbpg_pkg::MODE_RAINBOW: begin
                    last_next  = now_reg;
                    phase_next = phase_reg + 8'd1;
                    dec_col    = rgbpg_pkg::wheel(phase_reg + 8'd1);
                    dec_load   = 1'b1;
                    dispatch   = rgbpg_pkg::PC_SCALE;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_reg         <= '0;
            phase_reg        <= 8'd0;
            pulse_level_reg  <= 8'd0;
            pulse_rising_reg <= 1'b1;
        end else if (decode) begin
            last_reg         <= last_next;
            phase_reg        <= phase_next;
            pulse_level_reg  <= pulse_level_next;
            pulse_rising_reg <= pulse_rising_next;
        end
    end

    // item capture and datapath registers
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            op_reg  <= s_op;
            now_reg <= s_now_ms;
        end
        if (decode && dec_load) begin
            col_reg   <= dec_col;
            scale_reg <= brightness_reg;
        end else begin
            case (uw.dst)
                rgbpg_pkg::D_SCALE: scale_reg  <= quot;
                rgbpg_pkg::D_RED:   col_reg[2] <= quot;
                rgbpg_pkg::D_GREEN: col_reg[1] <= quot;
                rgbpg_pkg::D_BLUE:  col_reg[0] <= quot;
                default: ;
            endcase
        end
    end

    // output register
    always_comb begin
        m_valid_next = m_valid_reg;
        if (emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_red_reg   <= col_reg[2];
            m_green_reg <= col_reg[1];
            m_blue_reg  <= col_reg[0];
        end
    end

    assign m_valid = m_valid_reg;
    assign m_red   = m_red_reg;
    assign m_green = m_green_reg;
    assign m_blue  = m_blue_reg;

    `RGBPG_ASSERT_NXT(a_busy_after_xfer, aclk, aresetn, s_xfer, !s_ready)
    `RGBPG_ASSERT_NXT(a_emit_loads, aclk, aresetn, emit, m_valid && m_red == $past(col_reg[2]))
    `RGBPG_ASSERT_IMP(a_fall_floor, aclk, aresetn, !pulse_rising_reg, pulse_level_reg >= rgbpg_pkg::PULSE_TURN)

endmodule

`default_nettype wire

// ===== hdl/rgbpg_scaler.sv =====
// 8x8 multiply with registered product, followed by exact division by 255.
// No dependencies.
`default_nettype none

module rgbpg_scaler (
    input  wire logic       aclk,
    input  wire logic [7:0] a,
    input  wire logic [7:0] b,
    output logic [7:0]      quot
);

    logic [15:0] prod_reg;
    logic [15:0] sum;

    always_ff @(posedge aclk) begin
        prod_reg <= 16'(a) * 16'(b);
    end

    // floor(x/255) = (x + (x >> 8) + 1) >> 8 for x up to 255*255
    assign sum  = prod_reg + {8'd0, prod_reg[15:8]} + 16'd1;
    assign quot = sum[15:8];

endmodule

`default_nettype wire

// ===== hdl/rgbpg_seq.sv =====
// Microcode sequencer: step counter, control store and jump logic.
// Depends on rgbpg_pkg.
`default_nettype none

module rgbpg_seq (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire rgbpg_pkg::seq_cond_t cond,
    output rgbpg_pkg::uword_t         uw
);

    rgbpg_pkg::pc_t pc_reg;
    rgbpg_pkg::pc_t pc_next;

    assign uw = rgbpg_pkg::ucode(pc_reg);

    always_comb begin
        pc_next = pc_reg;
        case (uw.jmp)
            rgbpg_pkg::J_NEXT:     pc_next = pc_reg + rgbpg_pkg::pc_t'(1);
            rgbpg_pkg::J_WAIT_IN:  pc_next = cond.in_xfer ? rgbpg_pkg::PC_DECODE : pc_reg;
            rgbpg_pkg::J_DISPATCH: pc_next = cond.dispatch;
            rgbpg_pkg::J_GOTO:     pc_next = uw.target;
            rgbpg_pkg::J_WAIT_OUT: pc_next = cond.out_free ? uw.target : pc_reg;
            default:               pc_next = rgbpg_pkg::PC_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= rgbpg_pkg::PC_IDLE;
        end else begin
            pc_reg <= pc_next;
        end
    end

endmodule

`default_nettype wire
